[hdl/rdp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rdp_pkg: shared definitions of the positional ring deque
// Command and status codes, field widths and the packed item and result
// records that travel between the top level and the sequencer.
// ----------------------------------------------------------------------------
package rdp_pkg;

    // Field widths fixed by the stream format.
    localparam int CMD_W   = 4;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;
    localparam int LEN_W   = 5;
    localparam int ST_W    = 2;

    // Default storage geometry.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 4'd0,
        CMD_PUSH_BACK  = 4'd1,
        CMD_INSERT_AT  = 4'd2,
        CMD_POP_FRONT  = 4'd3,
        CMD_POP_BACK   = 4'd4,
        CMD_REMOVE_AT  = 4'd5,
        CMD_READ_AT    = 4'd6,
        CMD_WRITE_AT   = 4'd7,
        CMD_CLEAR      = 4'd8
    } t_cmd;

    // Status codes.
    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Input item, last field in the lowest bits.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] position;
        logic [CMD_W-1:0] command;
    } t_item;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic             is_full;
        logic             is_empty;
        logic [LEN_W-1:0] length_now;
        logic [VAL_W-1:0] read_data;
    } t_result;

    localparam int ITEM_W    = $bits(t_item);
    localparam int RES_W     = $bits(t_result);
    localparam int S_TDATA_W = ((ITEM_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage
`default_nettype wire

[hdl/rdp_ring_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rdp_ring_ram: ring slot storage
// Simple dual-port synchronous memory, one write and one read port, with
// registered read data.
// ----------------------------------------------------------------------------
module rdp_ring_ram #(
    parameter int DEPTH      = rdp_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rdp_pkg::DATA_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire  [$clog2(DEPTH)-1:0]     i_waddr,
    input  wire  [DATA_WIDTH-1:0]        i_wdata,
    input  wire                          i_re,
    input  wire  [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [DATA_WIDTH-1:0]        o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[hdl/rdp_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rdp_seq: command sequencer of the positional ring deque
// Holds the front index and the element count, decodes one command at a
// time and drives the ring memory. Positional insert and remove walk the
// nearer side one element per cycle, reading one slot while writing the
// slot read in the cycle before.
// ----------------------------------------------------------------------------
module rdp_seq #(
    parameter int DEPTH      = rdp_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rdp_pkg::DATA_WIDTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // Configuration: effective capacity and its write strobe.
    input  wire                            i_cfg_we,
    input  wire  [rdp_pkg::CAP_W-1:0]      i_cap,
    // Command side.
    input  wire                            i_start,
    input  rdp_pkg::t_item                 i_item,
    output logic                           o_ready,
    // Result side.
    input  wire                            i_out_free,
    output logic                           o_res_load,
    output rdp_pkg::t_result               o_res,
    // Ring memory.
    output logic                           o_ram_we,
    output logic [$clog2(DEPTH)-1:0]       o_ram_waddr,
    output logic [DATA_WIDTH-1:0]          o_ram_wdata,
    output logic                           o_ram_re,
    output logic [$clog2(DEPTH)-1:0]       o_ram_raddr,
    input  wire  [DATA_WIDTH-1:0]          i_ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = rdp_pkg::POS_W;
    localparam int LW = rdp_pkg::POS_W + 2;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_MOVE   = 6'b000100,
        S_FINAL  = 6'b001000,
        S_RDWAIT = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    // Physical slot of logical index k, where k runs from -1 to capacity.
    function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] front,
                                              input logic [PW-1:0] cap,
                                              input logic signed [LW-1:0] k);
        logic signed [LW-1:0] c;
        logic signed [LW-1:0] sum;
        c   = $signed({2'b00, cap});
        sum = $signed({2'b00, front}) + k;
        if (sum < 0) begin
            sum = sum + c;
        end else if (sum >= c) begin
            sum = sum - c;
        end
        return PW'(sum);
    endfunction

    // Unsigned count or position as a signed logical index.
    function automatic logic signed [LW-1:0] lg(input logic [PW-1:0] x);
        return $signed({2'b00, x});
    endfunction

    t_state                  r_state,  n_state;
    rdp_pkg::t_item          r_item,   n_item;
    logic [PW-1:0]           r_front,  n_front;
    logic [PW-1:0]           r_count,  n_count;
    logic [rdp_pkg::ST_W-1:0] r_status, n_status;
    logic [rdp_pkg::VAL_W-1:0] r_rd,   n_rd;
    logic signed [LW-1:0]    r_src,    n_src;
    logic signed [LW-1:0]    r_wdst,   n_wdst;
    logic [PW-1:0]           r_left,   n_left;
    logic                    r_wpend,  n_wpend;
    logic                    r_ins,    n_ins;
    logic                    r_dn,     n_dn;

    logic                    ram_we;
    logic                    ram_re;
    logic [PW-1:0]           ram_wslot;
    logic [PW-1:0]           ram_rslot;
    logic [DATA_WIDTH-1:0]   ram_wdata;
    logic [PW-1:0]           slot_back;
    logic [PW-1:0]           slot_fwd;
    logic [PW-1:0]           slot_pos;
    logic [PW-1:0]           half;
    logic signed [LW-1:0]    dd;
    logic [PW-1:0]           pos;

    assign pos       = r_item.position;
    assign half      = r_count >> 1;
    assign slot_back = slot_of(r_front, i_cap, -LW'(1));
    assign slot_fwd  = slot_of(r_front, i_cap, LW'(1));
    assign slot_pos  = slot_of(r_front, i_cap, lg(pos));
    // Destination offset of a move; the source walks the other way.
    assign dd        = r_dn ? -LW'(1) : LW'(1);

    // Next-state and memory control.
    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_front   = r_front;
        n_count   = r_count;
        n_status  = r_status;
        n_rd      = r_rd;
        n_src     = r_src;
        n_wdst    = r_wdst;
        n_left    = r_left;
        n_wpend   = 1'b0;
        n_ins     = r_ins;
        n_dn      = r_dn;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_wslot = '0;
        ram_rslot = '0;
        ram_wdata = DATA_WIDTH'(r_item.value);

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item  = i_item;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_status = rdp_pkg::ST_DONE;
                n_rd     = '0;
                n_state  = S_DONE;
                case (r_item.command)
                    rdp_pkg::CMD_PUSH_FRONT, rdp_pkg::CMD_PUSH_BACK,
                    rdp_pkg::CMD_INSERT_AT: begin
                        if (r_count >= i_cap) begin
                            n_status = rdp_pkg::ST_FULL;
                        end else if (r_item.command == rdp_pkg::CMD_PUSH_BACK ||
                                     (r_item.command == rdp_pkg::CMD_INSERT_AT &&
                                      pos >= r_count)) begin
                            // Append at the back.
                            ram_we    = 1'b1;
                            ram_wslot = slot_of(r_front, i_cap, lg(r_count));
                            n_count   = r_count + 1'b1;
                        end else if (r_item.command == rdp_pkg::CMD_PUSH_FRONT ||
                                     pos == '0) begin
                            // Step the front back by one and store there.
                            ram_we    = 1'b1;
                            ram_wslot = slot_back;
                            n_front   = slot_back;
                            n_count   = r_count + 1'b1;
                        end else if (pos >= half) begin
                            // Open a gap by moving the back part up.
                            n_ins   = 1'b1;
                            n_dn    = 1'b0;
                            n_src   = lg(r_count) - LW'(1);
                            n_left  = r_count - pos;
                            n_state = S_MOVE;
                        end else begin
                            // Open a gap by moving the front part down.
                            n_ins   = 1'b1;
                            n_dn    = 1'b1;
                            n_src   = '0;
                            n_left  = pos;
                            n_state = S_MOVE;
                        end
                    end

                    rdp_pkg::CMD_POP_FRONT, rdp_pkg::CMD_POP_BACK,
                    rdp_pkg::CMD_REMOVE_AT: begin
                        if (r_count == '0) begin
                            n_status = rdp_pkg::ST_EMPTY;
                        end else if (r_item.command == rdp_pkg::CMD_REMOVE_AT &&
                                     pos >= r_count) begin
                            n_status = rdp_pkg::ST_RANGE;
                        end else if (r_item.command == rdp_pkg::CMD_POP_FRONT ||
                                     (r_item.command == rdp_pkg::CMD_REMOVE_AT &&
                                      pos == '0 && r_count > PW'(1))) begin
                            n_front = slot_fwd;
                            n_count = r_count - 1'b1;
                        end else if (r_item.command == rdp_pkg::CMD_POP_BACK ||
                                     pos == r_count - 1'b1) begin
                            n_count = r_count - 1'b1;
                        end else if (pos >= half) begin
                            // Close the gap by moving the back part down.
                            n_ins   = 1'b0;
                            n_dn    = 1'b1;
                            n_src   = lg(pos) + LW'(1);
                            n_left  = r_count - 1'b1 - pos;
                            n_state = S_MOVE;
                        end else begin
                            // Close the gap by moving the front part up.
                            n_ins   = 1'b0;
                            n_dn    = 1'b0;
                            n_src   = lg(pos) - LW'(1);
                            n_left  = pos;
                            n_state = S_MOVE;
                        end
                    end

                    rdp_pkg::CMD_READ_AT: begin
                        if (pos >= r_count) begin
                            n_status = rdp_pkg::ST_RANGE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_rslot = slot_pos;
                            n_state   = S_RDWAIT;
                        end
                    end

                    rdp_pkg::CMD_WRITE_AT: begin
                        if (pos >= r_count) begin
                            n_status = rdp_pkg::ST_RANGE;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wslot = slot_pos;
                        end
                    end

                    rdp_pkg::CMD_CLEAR: begin
                        n_front = '0;
                        n_count = '0;
                    end

                    default: begin
                        // Unused codes change nothing.
                    end
                endcase
            end

            S_MOVE: begin
                // Issue the next source read.
                if (r_left != '0) begin
                    ram_re    = 1'b1;
                    ram_rslot = slot_of(r_front, i_cap, r_src);
                    n_src     = r_src - dd;
                    n_wdst    = r_src + dd;
                    n_left    = r_left - 1'b1;
                    n_wpend   = 1'b1;
                end
                // Store the element read in the cycle before.
                if (r_wpend) begin
                    ram_we    = 1'b1;
                    ram_wslot = slot_of(r_front, i_cap, r_wdst);
                    ram_wdata = i_ram_rdata;
                end
                if (r_left == '0) begin
                    n_state = S_FINAL;
                end
            end

            S_FINAL: begin
                n_state = S_DONE;
                if (r_ins) begin
                    ram_we = 1'b1;
                    if (r_dn) begin
                        ram_wslot = slot_of(r_front, i_cap, lg(pos) - LW'(1));
                        n_front   = slot_back;
                    end else begin
                        ram_wslot = slot_pos;
                    end
                    n_count = r_count + 1'b1;
                end else begin
                    if (!r_dn) begin
                        n_front = slot_fwd;
                    end
                    n_count = r_count - 1'b1;
                end
            end

            S_RDWAIT: begin
                n_rd    = rdp_pkg::VAL_W'(i_ram_rdata);
                n_state = S_DONE;
            end

            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A capacity write empties the deque.
        if (i_cfg_we) begin
            n_front = '0;
            n_count = '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_left  <= '0;
            r_wpend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_left  <= n_left;
            r_wpend <= n_wpend;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_status <= n_status;
        r_rd     <= n_rd;
        r_src    <= n_src;
        r_wdst   <= n_wdst;
        r_ins    <= n_ins;
        r_dn     <= n_dn;
    end

    // Outputs.
    assign o_ready     = (r_state == S_IDLE);
    assign o_res_load  = (r_state == S_DONE) && i_out_free;
    assign o_ram_we    = ram_we;
    assign o_ram_waddr = AW'(ram_wslot);
    assign o_ram_wdata = ram_wdata;
    assign o_ram_re    = ram_re;
    assign o_ram_raddr = AW'(ram_rslot);

    always_comb begin
        o_res            = '0;
        o_res.read_data  = r_rd;
        o_res.length_now = r_count;
        o_res.is_empty   = (r_count == '0);
        o_res.is_full    = (r_count == i_cap);
        o_res.status     = r_status;
    end

    // The element count never exceeds the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= i_cap)
        else $error("element count above capacity");

    // The front index always names a slot inside the capacity.
    a_front_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front < i_cap)
        else $error("front index outside the ring");

    // A move never reads the slot that it writes in the same cycle.
    a_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram_we && o_ram_re) |-> (o_ram_waddr != o_ram_raddr))
        else $error("read and write of one slot in one cycle");

    // An idle sequencer leaves the memory alone.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!o_ram_we && !o_ram_re))
        else $error("memory access while idle");

endmodule
`default_nettype wire

[hdl/ring_deque_positional.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ring_deque_positional: circular deque with positional insert and remove
// Top level: stream ports, capacity register, result output register, the
// command sequencer and the ring memory.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Contents
//  s_axis    in         tvalid/tready          command, position, value
//  m_axis    out        tvalid/tready          read_data, length, flags, status
//  cfg       in         i_cfg_we, no wait      capacity
//
// Push, pop, write and clear pass through the decode and done states to a valid
// result, a read also through a read-wait state. A positional insert or remove
// that moves n elements, n being at most about half the held count, adds a move
// and a final state; the single read and single write port of the ring memory
// move one element per cycle. One command is in work at a time; the next is
// accepted while a result waits in the output register, and a stalled output
// holds the sequencer in its done state. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module ring_deque_positional #(
    parameter int DEPTH      = rdp_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rdp_pkg::DATA_WIDTH_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Command stream.
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: command[3:0], position[8:4], value[40:9], zeros above.
    input  wire  [rdp_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // Result stream.
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // tdata: read_data[31:0], length_now[36:32], is_empty[37], is_full[38],
    // status[40:39], zeros above.
    output logic [rdp_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // Capacity register write.
    input  wire                               i_cfg_we,
    input  wire  [rdp_pkg::CAP_W-1:0]         i_cfg_wdata
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CAP_MAX = 2 ** rdp_pkg::CAP_W - 1;
    localparam int CAP_RST = (DEPTH > CAP_MAX) ? CAP_MAX : DEPTH;
    localparam int PAD_W   = rdp_pkg::M_TDATA_W - rdp_pkg::RES_W;

    logic [rdp_pkg::CAP_W-1:0] r_cap, n_cap;
    logic                      r_m_valid;
    rdp_pkg::t_result          r_m_res;

    logic                      seq_ready;
    logic                      res_load;
    rdp_pkg::t_result          seq_res;
    rdp_pkg::t_item            in_item;
    logic                      out_free;
    logic                      ram_we;
    logic                      ram_re;
    logic [AW-1:0]             ram_waddr;
    logic [AW-1:0]             ram_raddr;
    logic [DATA_WIDTH-1:0]     ram_wdata;
    logic [DATA_WIDTH-1:0]     ram_rdata;

    // Capacity written as zero acts as one, above the ring size as the ring size.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_cap = rdp_pkg::CAP_W'(1);
        end else if (int'(i_cfg_wdata) > DEPTH) begin
            n_cap = rdp_pkg::CAP_W'(DEPTH);
        end else begin
            n_cap = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= rdp_pkg::CAP_W'(CAP_RST);
        end else if (i_cfg_we) begin
            r_cap <= n_cap;
        end
    end

    // Input transfer.
    assign in_item       = rdp_pkg::t_item'(s_axis_tdata[rdp_pkg::ITEM_W-1:0]);
    assign s_axis_tready = seq_ready;

    // Output register, refilled in the cycle its content is taken.
    assign out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_m_res <= seq_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_m_res};

    // Command sequencer.
    rdp_seq #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cap       (r_cap),
        .i_start     (s_axis_tvalid && seq_ready),
        .i_item      (in_item),
        .o_ready     (seq_ready),
        .i_out_free  (out_free),
        .o_res_load  (res_load),
        .o_res       (seq_res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // Ring slot memory.
    rdp_ring_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
`default_nettype wire
